// ===== hdl/nonlocal_means_sample_filter_macros.svh =====
// Assertion macros for the non-local-means sample filter.
// Expects clk_i and rst_ni in the scope that uses them.
`ifndef NONLOCAL_MEANS_SAMPLE_FILTER_MACROS_SVH
`define NONLOCAL_MEANS_SAMPLE_FILTER_MACROS_SVH

// Checked on every rising edge outside reset.
`define NLMSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define NLMSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/nlmsf_pkg.sv =====
`timescale 1ns / 1ps
// Constants and the weight table function of the non-local-means sample filter.
// No dependencies.
package nlmsf_pkg;

  localparam int WINDOW_TAPS_DEF     = 21;
  localparam int TEMPLATE_TAPS_DEF   = 7;
  localparam int EXP_TABLE_DEPTH_DEF = 256;

  localparam int SAMPLE_W   = 10;
  localparam int SAMPLE_MAX = 1023;
  localparam int FILT_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int WEIGHT_W   = 17;
  localparam int FRAC_BITS  = 6;
  localparam int DIV_BITS   = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET     = 16'd20450;
  localparam logic [63:0]       DECAY_STEP_Q32 = 64'd4034748382;

  // Weight k = exp(-k/16) in Q16, built by the Q32 decay recurrence.
  // Only evaluated at elaboration with a constant index.
  function automatic logic [WEIGHT_W-1:0] exp_weight(input int k);
    logic [63:0] a;
    a = 64'd1 << 32;
    for (int j = 0; j < k; j++) begin
      a = (a * DECAY_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    return WEIGHT_W'((a + (64'd1 << 15)) >> 16);
  endfunction

endpackage

// ===== hdl/nonlocal_means_sample_filter.sv =====
`timescale 1ns / 1ps
// Top level of the non-local-means sample filter: sample line, sequencer,
// shared multiplier and bit-serial divider. Depends on nlmsf_pkg and the macro header.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_stall_o    sample_i[9:0]
//   out      out  out_valid_o/out_stall_i  filtered_o[15:0]
//   cfg      in   cfg_we_i                 cfg_wdata_i[15:0] (decay gain)
//
// At each window position the shared multiplier squares the template
// difference, scales it by the gain and multiplies weight by sample.
// The divider retires one quotient bit per cycle.
// Reset is asynchronous, active low; the sample line needs no clearing pass.
// in_stall_o is high while an item is at work; a result still held in the output
// register keeps the next item in its last step until the register frees.
`include "nonlocal_means_sample_filter_macros.svh"

module nonlocal_means_sample_filter #(
  parameter int WINDOW_TAPS     = nlmsf_pkg::WINDOW_TAPS_DEF,
  parameter int TEMPLATE_TAPS   = nlmsf_pkg::TEMPLATE_TAPS_DEF,
  parameter int EXP_TABLE_DEPTH = nlmsf_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nlmsf_pkg::GAIN_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [nlmsf_pkg::SAMPLE_W-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [nlmsf_pkg::FILT_W-1:0]  filtered_o
);

  localparam int FULL_TAPS = WINDOW_TAPS + TEMPLATE_TAPS - 1;
  localparam int HALF_TAPS = TEMPLATE_TAPS / 2;
  localparam int MID_TAP   = FULL_TAPS / 2;
  localparam int FIRST_POS = FULL_TAPS - 1 - HALF_TAPS;

  localparam int AW     = $clog2(FULL_TAPS);
  localparam int CNT_W  = $clog2(FULL_TAPS + 1);
  localparam int LW     = CNT_W + 2;
  localparam int K_W    = $clog2(2 * HALF_TAPS + 2);
  localparam int I_W    = $clog2(WINDOW_TAPS);
  localparam int SUM_W  = $clog2((2 * HALF_TAPS + 1) * nlmsf_pkg::SAMPLE_MAX + 1);
  localparam int MA_W   = (2 * SUM_W > nlmsf_pkg::WEIGHT_W) ? 2 * SUM_W : nlmsf_pkg::WEIGHT_W;
  localparam int P_W    = MA_W + nlmsf_pkg::GAIN_W;
  localparam int WS_W   = $clog2(WINDOW_TAPS * 65536 + 1);
  localparam int ACC_W  = $clog2(longint'(WINDOW_TAPS) * 65536 * nlmsf_pkg::SAMPLE_MAX + 1);
  localparam int NUM_W  = ACC_W + nlmsf_pkg::FRAC_BITS + 1;
  localparam int LUT_AW = $clog2(EXP_TABLE_DEPTH);
  localparam int DC_W   = $clog2(nlmsf_pkg::DIV_BITS);
  localparam int SW     = nlmsf_pkg::SAMPLE_W;
  localparam int WW     = nlmsf_pkg::WEIGHT_W;
  localparam int GW     = nlmsf_pkg::GAIN_W;
  localparam int FW     = nlmsf_pkg::FILT_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SUMS = 4'd1;
  localparam logic [3:0] ST_SQ   = 4'd2;
  localparam logic [3:0] ST_GAIN = 4'd3;
  localparam logic [3:0] ST_LOOK = 4'd4;
  localparam logic [3:0] ST_WX   = 4'd5;
  localparam logic [3:0] ST_FIN  = 4'd6;
  localparam logic [3:0] ST_DIVI = 4'd7;
  localparam logic [3:0] ST_DIV  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  // Weight table, constant logic.
  logic [WW-1:0] weight_lut [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_lut
    assign weight_lut[g] = nlmsf_pkg::exp_weight(g);
  end

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [AW-1:0]    head_q, head_d;
  logic [GW-1:0]    gain_q;
  logic [K_W-1:0]   k_q, k_d;
  logic [I_W-1:0]   i_q, i_d;
  logic [DC_W-1:0]  div_cnt_q, div_cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [FW-1:0]    out_q, out_d;

  logic [SW-1:0]    line_mem [FULL_TAPS];
  logic [SW-1:0]    rd_a_q, rd_b_q;
  logic             rd_a_ok_q, rd_b_ok_q;
  logic [SW-1:0]    rd_a_m, rd_b_m;

  logic [LW-1:0]    la_a, la_b, pos_q, pos_d;
  logic             ok_a, ok_b;
  logic [AW-1:0]    pa_a, pa_b, wr_addr;
  logic             accept, wr_en;

  logic [SUM_W-1:0] centre_q, centre_d, s_q, s_d, diff;
  logic [SW-1:0]    x_q, x_d;
  logic [WW-1:0]    w_q, w_d, lut_w;
  logic [MA_W-1:0]  mul_a, idx;
  logic [GW-1:0]    mul_b;
  logic [P_W-1:0]   prod_q, prod_d, mul_p;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [WS_W-1:0]  wsum_q, wsum_d, rem_q, rem_d;
  logic [FW-1:0]    quo_q, quo_d;
  logic [NUM_W-1:0] num;
  logic [WS_W:0]    rem_sh;
  logic             rem_ge;

  function automatic logic [AW-1:0] phys_addr(input logic [LW-1:0] la,
                                              input logic [AW-1:0] head);
    logic [AW:0] sum;
    sum = (AW+1)'(head) + (AW+1)'(la[AW-1:0]);
    if (sum >= (AW+1)'(FULL_TAPS)) begin
      return AW'(sum - (AW+1)'(FULL_TAPS));
    end
    return sum[AW-1:0];
  endfunction

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_q;

  // Line write: fill slot cnt while filling, else overwrite the oldest slot.
  assign wr_en   = accept;
  assign wr_addr = (cnt_q == CNT_W'(FULL_TAPS)) ? head_q : cnt_q[AW-1:0];

  // Logical read indices per step of the sequence.
  always_comb begin
    la_a = '0;
    la_b = '0;
    unique case (state_q)
      ST_SUMS: begin
        la_a = LW'(MID_TAP - HALF_TAPS) + LW'(k_q);
        la_b = LW'(FIRST_POS - HALF_TAPS) + LW'(k_q);
      end
      ST_SQ: begin
        la_a = pos_q;
      end
      ST_GAIN: begin
        la_a = pos_q + LW'(HALF_TAPS);
        la_b = pos_q - LW'(HALF_TAPS + 1);
      end
      default: begin
        la_a = '0;
        la_b = '0;
      end
    endcase
  end

  // Slots outside the line or not yet written read as zero.
  assign ok_a = !la_a[LW-1] && (la_a[LW-2:0] < (LW-1)'(cnt_q));
  assign ok_b = !la_b[LW-1] && (la_b[LW-2:0] < (LW-1)'(cnt_q));
  assign pa_a = phys_addr(la_a, head_q);
  assign pa_b = phys_addr(la_b, head_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[wr_addr] <= sample_i;
    end
    rd_a_q    <= line_mem[pa_a];
    rd_b_q    <= line_mem[pa_b];
    rd_a_ok_q <= ok_a;
    rd_b_ok_q <= ok_b;
  end

  assign rd_a_m = rd_a_ok_q ? rd_a_q : '0;
  assign rd_b_m = rd_b_ok_q ? rd_b_q : '0;

  // Shared multiplier and its operand select.
  assign diff = (s_q >= centre_q) ? (s_q - centre_q) : (centre_q - s_q);
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQ: begin
        mul_a = MA_W'(diff);
        mul_b = GW'(diff);
      end
      ST_GAIN: begin
        mul_a = prod_q[MA_W-1:0];
        mul_b = gain_q;
      end
      ST_WX: begin
        mul_a = MA_W'(w_q);
        mul_b = GW'(x_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = P_W'(mul_a) * P_W'(mul_b);

  assign idx   = prod_q[P_W-1:GW];
  assign lut_w = (idx < MA_W'(EXP_TABLE_DEPTH)) ? weight_lut[idx[LUT_AW-1:0]] : '0;

  assign num = (NUM_W'(acc_q) << nlmsf_pkg::FRAC_BITS) + NUM_W'(wsum_q >> 1);

  assign rem_sh = {rem_q, quo_q[FW-1]};
  assign rem_ge = (rem_sh >= (WS_W+1)'(wsum_q));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    k_d         = k_q;
    i_d         = i_q;
    div_cnt_d   = div_cnt_q;
    pos_d       = pos_q;
    centre_d    = centre_q;
    s_d         = s_q;
    x_d         = x_q;
    w_d         = w_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    wsum_d      = wsum_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cnt_q == CNT_W'(FULL_TAPS)) begin
            head_d = (head_q == AW'(FULL_TAPS - 1)) ? '0 : head_q + 1'b1;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
          k_d      = '0;
          centre_d = '0;
          s_d      = '0;
          acc_d    = '0;
          wsum_d   = '0;
          prod_d   = '0;
          state_d  = ST_SUMS;
        end
      end
      ST_SUMS: begin
        // Read data is registered, so it lags the address.
        if (k_q != '0) begin
          centre_d = centre_q + SUM_W'(rd_a_m);
          s_d      = s_q + SUM_W'(rd_b_m);
        end
        if (k_q == K_W'(2 * HALF_TAPS + 1)) begin
          i_d     = '0;
          pos_d   = LW'(FIRST_POS);
          state_d = ST_SQ;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_SQ: begin
        acc_d   = acc_q + prod_q[ACC_W-1:0];
        prod_d  = mul_p;
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        prod_d  = mul_p;
        x_d     = rd_a_m;
        state_d = ST_LOOK;
      end
      ST_LOOK: begin
        w_d     = lut_w;
        // Slide the template one tap toward slot 0.
        s_d     = s_q - SUM_W'(rd_a_m) + SUM_W'(rd_b_m);
        pos_d   = pos_q - 1'b1;
        state_d = ST_WX;
      end
      ST_WX: begin
        prod_d = mul_p;
        wsum_d = wsum_q + WS_W'(w_q);
        if (i_q == I_W'(WINDOW_TAPS - 1)) begin
          state_d = ST_FIN;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_SQ;
        end
      end
      ST_FIN: begin
        acc_d   = acc_q + prod_q[ACC_W-1:0];
        state_d = ST_DIVI;
      end
      ST_DIVI: begin
        if (wsum_q == '0) begin
          quo_d   = '0;
          state_d = ST_DONE;
        end else begin
          // Quotient fits 16 bits, so the top part starts below the divisor.
          rem_d     = num[FW +: WS_W];
          quo_d     = num[FW-1:0];
          div_cnt_d = '0;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = rem_ge ? WS_W'(rem_sh - (WS_W+1)'(wsum_q)) : rem_sh[WS_W-1:0];
        quo_d = {quo_q[FW-2:0], rem_ge};
        if (div_cnt_q == DC_W'(nlmsf_pkg::DIV_BITS - 1)) begin
          state_d = ST_DONE;
        end else begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_d       = quo_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      head_q      <= '0;
      gain_q      <= nlmsf_pkg::GAIN_RESET;
      k_q         <= '0;
      i_q         <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      k_q         <= k_d;
      i_q         <= i_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    centre_q <= centre_d;
    s_q      <= s_d;
    x_q      <= x_d;
    w_q      <= w_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    wsum_q   <= wsum_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    out_q    <= out_d;
  end

  `NLMSF_ASSERT(a_head_still_while_filling, (cnt_q != CNT_W'(FULL_TAPS)) |-> (head_q == '0), "line head moved before the line was full")
  `NLMSF_ASSERT(a_div_rem_below_divisor, (state_q == ST_DIV) |-> (rem_q < wsum_q), "divider remainder not below weight sum")
  `NLMSF_ASSERT_ALWAYS(a_line_ptr_range, rst_ni |-> ((CNT_W'(head_q) < CNT_W'(FULL_TAPS)) && (cnt_q <= CNT_W'(FULL_TAPS))), "line head or fill count out of range")

endmodule
